>>> rtl/b64_pkg.sv
package b64_pkg;

	// codec_mode values
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BADCHAR = 2'd1;
	localparam logic [1:0] ST_BADLEN  = 2'd2;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// results one item can give at most
	localparam int unsigned MAX_RESULTS = 4;
	localparam int unsigned RES_CNT_W = $clog2(MAX_RESULTS + 1);
	localparam int unsigned RES_IDX_W = $clog2(MAX_RESULTS);

	// sextet to standard alphabet character
	function automatic logic [7:0] sextet_to_char(logic [5:0] s);
		logic [7:0] w;
		w = {2'b00, s};
		if (s < 6'd26) begin
			return w + 8'd65;
		end else if (s < 6'd52) begin
			return w + 8'd71;
		end else if (s < 6'd62) begin
			return w - 8'd4;
		end else if (s == 6'd62) begin
			return 8'h2B;
		end else begin
			return 8'h2F;
		end
	endfunction

	// character to {not_in_alphabet, sextet}; outside characters give sextet 0
	function automatic logic [6:0] char_to_sextet(logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			d = c - 8'd65;
			return {1'b0, d[5:0]};
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			d = c - 8'd71;
			return {1'b0, d[5:0]};
		end else if (c >= 8'h30 && c <= 8'h39) begin
			d = c + 8'd4;
			return {1'b0, d[5:0]};
		end else if (c == 8'h2B) begin
			return {1'b0, 6'd62};
		end else if (c == 8'h2F) begin
			return {1'b0, 6'd63};
		end else begin
			return {1'b1, 6'd0};
		end
	endfunction

endpackage

>>> rtl/base64_stream_codec.sv
// base64 codec (standard alphabet) over a byte stream
//
// cfg_we/cfg_wdata write the mode: 0 encodes raw bytes into base64 text,
// 1 decodes base64 text into bytes. A write also drops any partial group;
// write only while the block is idle.
// input channel in_valid/in_ready carries one symbol per item with in_last
// on the final item of a message. Output channel out_valid/out_ready
// carries one symbol per item, out_last on the final result and status
// (ok, bad character, bad decode length) on that final result only.
// Each input item is folded into the group registers in the cycle it is
// accepted; an item that completes a group loads up to four results into
// a small output buffer, so the first result shows in the next cycle.
// The buffer drains one result per cycle. A new item is taken while the
// buffer is empty, its last entry leaves in the same cycle or the item only
// joins the group, so decode runs at one item per cycle and encode is bound
// by the single output port. When the receiver stalls the buffer holds and
// in_ready drops as soon as a new group would need the buffer.
// Reset clears mode (encode), group state and the output buffer.
module base64_stream_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_symbol,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_symbol,
	output logic       out_last,
	output logic [1:0] status
);
	import b64_pkg::*;

	// configuration and group state
	logic        mode_q;
	logic [1:0]  cnt_q;
	logic [17:0] bits_q;
	logic        bad_q;
	logic        pad3_q;

	// output buffer
	logic [7:0]           buf_sym_q [MAX_RESULTS];
	logic [RES_CNT_W-1:0] rem_q;
	logic [RES_IDX_W-1:0] idx_q;
	logic                 buf_last_q;
	logic [1:0]           buf_st_q;

	logic in_acc;
	logic out_acc;

	// next group state and results of the accepted item
	logic [1:0]           cnt_d;
	logic [17:0]          bits_d;
	logic                 bad_d;
	logic                 pad3_d;
	logic [RES_CNT_W-1:0] emit_cnt;
	logic [7:0]           emit_sym [MAX_RESULTS];
	logic                 emit_last;
	logic [1:0]           emit_st;

	logic [6:0]  dec_char;
	logic [5:0]  sext;
	logic        is_pad;
	logic [2:0]  n_enc;
	logic [23:0] word;
	logic [1:0]  keep;

	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	// an item that only joins the group never needs the buffer
	assign in_ready  = (rem_q == '0) || ((rem_q == RES_CNT_W'(1)) && out_ready)
		|| (emit_cnt == '0);
	assign out_valid = (rem_q != '0);
	assign out_symbol = buf_sym_q[idx_q];
	assign out_last   = buf_last_q && (rem_q == RES_CNT_W'(1));
	assign status     = (rem_q == RES_CNT_W'(1)) ? buf_st_q : ST_OK;

	assign dec_char = char_to_sextet(in_symbol);
	assign sext     = dec_char[5:0];
	assign is_pad   = (in_symbol == PAD_CHAR);
	assign n_enc    = {1'b0, cnt_q} + 3'd1;

	always_comb begin
		cnt_d     = cnt_q;
		bits_d    = bits_q;
		bad_d     = bad_q;
		pad3_d    = pad3_q;
		emit_cnt  = '0;
		emit_last = 1'b0;
		emit_st   = ST_OK;
		word      = 24'd0;
		keep      = 2'd3;
		for (int k = 0; k < MAX_RESULTS; k++) begin
			emit_sym[k] = PAD_CHAR;
		end
		if (mode_q == MODE_ENC) begin
			if (n_enc < 3'd3 && !in_last) begin
				bits_d = {bits_q[9:0], in_symbol};
				cnt_d  = n_enc[1:0];
			end else begin
				// left-align the held bytes into one 24-bit word
				unique case (cnt_q)
					2'd0:    word = {in_symbol, 16'h0000};
					2'd1:    word = {bits_q[7:0], in_symbol, 8'h00};
					default: word = {bits_q[15:0], in_symbol};
				endcase
				emit_sym[0] = sextet_to_char(word[23:18]);
				emit_sym[1] = sextet_to_char(word[17:12]);
				if (cnt_q != 2'd0) begin
					emit_sym[2] = sextet_to_char(word[11:6]);
				end
				if (cnt_q == 2'd2) begin
					emit_sym[3] = sextet_to_char(word[5:0]);
				end
				emit_cnt  = RES_CNT_W'(MAX_RESULTS);
				emit_last = in_last;
				cnt_d     = 2'd0;
				bits_d    = 18'd0;
				if (in_last) begin
					bad_d  = 1'b0;
					pad3_d = 1'b0;
				end
			end
		end else begin
			if (dec_char[6] && !is_pad) begin
				bad_d = 1'b1;
			end
			if (cnt_q != 2'd3) begin
				if (in_last) begin
					// length not a multiple of four
					emit_sym[0] = 8'h00;
					emit_cnt    = RES_CNT_W'(1);
					emit_last   = 1'b1;
					emit_st     = ST_BADLEN;
					cnt_d       = 2'd0;
					bits_d      = 18'd0;
					bad_d       = 1'b0;
					pad3_d      = 1'b0;
				end else begin
					if (cnt_q == 2'd2) begin
						pad3_d = is_pad;
					end
					bits_d = {bits_q[11:0], sext};
					cnt_d  = cnt_q + 2'd1;
				end
			end else begin
				word = {bits_q, sext};
				if (in_last) begin
					keep = 2'd3 - {1'b0, is_pad} - {1'b0, pad3_q};
				end
				emit_sym[0] = word[23:16];
				emit_sym[1] = word[15:8];
				emit_sym[2] = word[7:0];
				emit_cnt    = RES_CNT_W'(keep);
				emit_last   = in_last;
				emit_st     = (in_last && bad_d) ? ST_BADCHAR : ST_OK;
				cnt_d       = 2'd0;
				bits_d      = 18'd0;
				pad3_d      = 1'b0;
				if (in_last) begin
					bad_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENC;
			cnt_q  <= 2'd0;
			bits_q <= 18'd0;
			bad_q  <= 1'b0;
			pad3_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
			cnt_q  <= 2'd0;
			bits_q <= 18'd0;
			bad_q  <= 1'b0;
			pad3_q <= 1'b0;
		end else if (in_acc) begin
			cnt_q  <= cnt_d;
			bits_q <= bits_d;
			bad_q  <= bad_d;
			pad3_q <= pad3_d;
		end
	end

	// buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q      <= '0;
			idx_q      <= '0;
			buf_last_q <= 1'b0;
			buf_st_q   <= ST_OK;
		end else if (in_acc && emit_cnt != '0) begin
			rem_q      <= emit_cnt;
			idx_q      <= '0;
			buf_last_q <= emit_last;
			buf_st_q   <= emit_st;
		end else if (out_acc) begin
			rem_q <= rem_q - RES_CNT_W'(1);
			idx_q <= idx_q + RES_IDX_W'(1);
		end
	end

	// buffer payload
	always_ff @(posedge clk) begin
		if (in_acc && emit_cnt != '0) begin
			for (int k = 0; k < MAX_RESULTS; k++) begin
				buf_sym_q[k] <= emit_sym[k];
			end
		end
	end

	// buffer never holds more than one group
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= RES_CNT_W'(MAX_RESULTS))
		else $error("output buffer count out of range");

	// a length error is always the final result
	a_badlen_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_BADLEN) |-> out_last)
		else $error("length error on a non-final result");

	// encoding never reports an error
	a_enc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && mode_q == MODE_ENC) |-> (status == ST_OK))
		else $error("error status while encoding");

	// an empty buffer always takes an item
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q == '0) |-> in_ready)
		else $error("input stalled with empty buffer");

	// a drained result advances the buffer unless a new group reloads it
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && !in_acc && rem_q > RES_CNT_W'(1))
		|=> (rem_q == $past(rem_q) - RES_CNT_W'(1)))
		else $error("output buffer did not advance");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import b64_pkg::*;

	localparam int N_DIRECTED = 24;
	localparam int N_PHASES = 6;
	localparam int PHASE_ITEMS = 50;
	// no handshake on either channel for this long means the block is stuck
	localparam int STALL_LIMIT = 2000;
	// the long receiver hold starts once this many results have gone out
	localparam int HOLD_AFTER = 150;
	localparam int HOLD_CYCLES = 120;
	// the first result shows in the cycle after the item, allow a generous margin
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam logic [511:0] B64_ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	typedef struct packed {
		logic [7:0] sym;
		logic       last;
		logic [1:0] st;
	} codec_result_t;

	// one row of the directed part; n_typed < 0 leaves the check to the predictor
	typedef struct {
		logic        wr_mode;
		logic        mode;
		logic [7:0]  sym;
		logic        last;
		int          n_typed;
		logic [31:0] typed_syms;
		logic [1:0]  typed_st;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic       cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_symbol;
	logic       in_last;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_symbol;
	logic       out_last;
	logic [1:0] status;

	// hand-typed results that travel with the current item
	int          typed_n = -1;
	logic [31:0] typed_syms = 32'd0;
	logic [1:0]  typed_st = ST_OK;

	// predictor copy of the block state
	logic        mode_q = MODE_ENC;
	logic [1:0]  held_count = 2'd0;
	logic [17:0] held_bits = 18'd0;
	logic        saw_bad_char = 1'b0;
	logic        third_is_pad = 1'b0;

	codec_result_t pending_results[$];
	codec_result_t step_results[$];

	int  err_count = 0;
	int  stall_cycles = 0;
	int  n_in = 0;
	int  n_out = 0;
	int  n_cfg = 0;
	int  n_end_ok = 0;
	int  n_end_badchar = 0;
	int  n_end_badlen = 0;
	logic no_gaps = 1'b0;
	logic hold_done = 1'b0;

	base64_stream_codec u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_symbol  (in_symbol),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_symbol (out_symbol),
		.out_last   (out_last),
		.status     (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sextet to alphabet character
	function automatic logic [7:0] b64_char(logic [5:0] k);
		return B64_ALPHABET[511 - 8 * int'(k) -: 8];
	endfunction

	// character to {outside alphabet, sextet}
	function automatic logic [6:0] char_sextet(logic [7:0] c);
		logic [7:0] d;
		d = 8'd0;
		if (c >= "A" && c <= "Z") begin
			d = c - "A";
		end else if (c >= "a" && c <= "z") begin
			d = c - "a" + 8'd26;
		end else if (c >= "0" && c <= "9") begin
			d = c - "0" + 8'd52;
		end else if (c == "+") begin
			d = 8'd62;
		end else if (c == "/") begin
			d = 8'd63;
		end else begin
			return {1'b1, 6'd0};
		end
		return {1'b0, d[5:0]};
	endfunction

	function automatic void clear_group();
		held_count = 2'd0;
		held_bits = 18'd0;
		saw_bad_char = 1'b0;
		third_is_pad = 1'b0;
	endfunction

	// folds one item into the group and lists the results it gives
	function automatic void codec_predict(logic [7:0] sym, logic last);
		int n;
		int keep;
		logic [23:0] word;
		logic [6:0] cs;
		logic [5:0] s;
		codec_result_t r;
		step_results.delete();
		if (mode_q == MODE_ENC) begin
			n = int'(held_count) + 1;
			if (n < 3 && !last) begin
				held_bits = {held_bits[9:0], sym};
				held_count = held_count + 2'd1;
			end else begin
				// left-align the held bytes, pad what is missing
				word = {held_bits[15:0], sym} << (8 * (3 - n));
				for (int k = 0; k < 4; k++) begin
					r.sym = (k < n + 1) ? b64_char(word[18 - 6 * k +: 6]) : PAD_CHAR;
					r.last = last && (k == 3);
					r.st = ST_OK;
					step_results.push_back(r);
				end
				if (last) begin
					clear_group();
				end else begin
					held_count = 2'd0;
					held_bits = 18'd0;
				end
			end
		end else begin
			cs = char_sextet(sym);
			s = 6'd0;
			if (sym != PAD_CHAR) begin
				s = cs[5:0];
				if (cs[6]) saw_bad_char = 1'b1;
			end
			if (held_count < 2'd3) begin
				if (last) begin
					// message length not a multiple of four
					r = '{8'd0, 1'b1, ST_BADLEN};
					step_results.push_back(r);
					clear_group();
				end else begin
					if (held_count == 2'd2) third_is_pad = (sym == PAD_CHAR);
					held_bits = {held_bits[11:0], s};
					held_count = held_count + 2'd1;
				end
			end else begin
				word = {held_bits, s};
				keep = 3;
				if (last) begin
					if (sym == PAD_CHAR) keep--;
					if (third_is_pad) keep--;
				end
				for (int k = 0; k < keep; k++) begin
					r.sym = word[16 - 8 * k +: 8];
					r.last = last && (k == keep - 1);
					r.st = (r.last && saw_bad_char) ? ST_BADCHAR : ST_OK;
					step_results.push_back(r);
				end
				if (last) begin
					clear_group();
				end else begin
					held_count = 2'd0;
					held_bits = 18'd0;
					third_is_pad = 1'b0;
				end
			end
		end
	endfunction

	// mostly back to back or short, now and then a long pause
	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one item and hold it until taken, then maybe pause
	task automatic send_symbol(input logic [7:0] sym, input logic last, input int tn,
		input logic [31:0] tw, input logic [1:0] ts);
		int g;
		in_valid <= 1'b1;
		in_symbol <= sym;
		in_last <= last;
		typed_n <= tn;
		typed_syms <= tw;
		typed_st <= ts;
		do @(posedge clk); while (!in_ready);
		g = random_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// stop offering, let every expected result out, then let the group logic settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_wdata <= m;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// predicts on every accepted item, checks every accepted result
	always @(posedge clk) begin : scoreboard
		codec_result_t want;
		if (arst_n) begin
			// a mode write drops any partial group
			if (cfg_we) begin
				mode_q = cfg_wdata;
				clear_group();
				n_cfg++;
			end
			if (in_valid && in_ready) begin
				codec_predict(in_symbol, in_last);
				if (typed_n < 0) begin
					foreach (step_results[k]) pending_results.push_back(step_results[k]);
				end else begin
					for (int k = 0; k < typed_n; k++) begin
						want.sym = typed_syms[31 - 8 * k -: 8];
						want.last = in_last && (k == typed_n - 1);
						want.st = want.last ? typed_st : ST_OK;
						pending_results.push_back(want);
					end
				end
				n_in++;
			end
			if (out_valid && out_ready) begin
				n_out++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result symbol %02h last %0b status %0d",
						$time, out_symbol, out_last, status);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (out_symbol !== want.sym) begin
						$display("%0t: out_symbol expected %02h actual %02h",
							$time, want.sym, out_symbol);
						err_count++;
					end
					if (out_last !== want.last) begin
						$display("%0t: out_last expected %0b actual %0b",
							$time, want.last, out_last);
						err_count++;
					end
					if (status !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.st, status);
						err_count++;
					end
				end
				if (out_last) begin
					case (status)
						ST_OK:      n_end_ok++;
						ST_BADCHAR: n_end_badchar++;
						ST_BADLEN:  n_end_badlen++;
						default:    ;
					endcase
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
	end

	// receiver: random ready stretches and gaps, plus one long hold
	// while the sender keeps offering, so the output buffer fills up
	initial begin : receiver
		int g;
		out_ready = 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			if (!hold_done && n_out >= HOLD_AFTER && in_valid) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
				g = random_gap();
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("%0t: timeout, no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		dir_row_t dir_rows [N_DIRECTED];
		logic phase_modes [N_PHASES];
		logic [7:0] msg_q [$];
		int sent;
		int ng;
		int len;
		int pads;
		logic abandon;

		// directed part: encode from reset, then decode
		dir_rows = '{
			// full group, typed
			'{1'b0, MODE_ENC, 8'h4D, 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_ENC, 8'h61, 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_ENC, 8'h6E, 1'b1, 4, "TWFu", ST_OK},
			// single byte at the top of the range, two pads
			'{1'b0, MODE_ENC, 8'hFF, 1'b1, 4, "/w==", ST_OK},
			// all-zero group then two top bytes, one pad
			'{1'b0, MODE_ENC, 8'h00, 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_ENC, 8'h00, 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_ENC, 8'h00, 1'b0, 4, "AAAA", ST_OK},
			'{1'b0, MODE_ENC, 8'hFF, 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_ENC, 8'hFF, 1'b1, 4, "//8=", ST_OK},
			// switch to decode, one pad drops the last byte
			'{1'b1, MODE_DEC, "/", 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, "/", 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, "8", 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, PAD_CHAR, 1'b1, 2, 32'hFFFF_0000, ST_OK},
			// pad in the second position is only a zero
			'{1'b0, MODE_DEC, "A", 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, PAD_CHAR, 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, "A", 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, PAD_CHAR, 1'b1, -1, 32'd0, ST_OK},
			// characters outside the alphabet at both extremes
			'{1'b0, MODE_DEC, 8'hFF, 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, 8'h00, 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, "A", 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, "A", 1'b1, 3, 32'd0, ST_BADCHAR},
			// message ends on the third character
			'{1'b0, MODE_DEC, "A", 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, "B", 1'b0, -1, 32'd0, ST_OK},
			'{1'b0, MODE_DEC, PAD_CHAR, 1'b1, 1, 32'd0, ST_BADLEN}
		};
		phase_modes = '{MODE_ENC, MODE_DEC, MODE_DEC, MODE_ENC, MODE_DEC, MODE_ENC};

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = MODE_ENC;
		in_valid = 1'b0;
		in_symbol = 8'd0;
		in_last = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			if (dir_rows[i].wr_mode) begin
				wait_idle();
				write_mode(dir_rows[i].mode);
			end
			send_symbol(dir_rows[i].sym, dir_rows[i].last, dir_rows[i].n_typed,
				dir_rows[i].typed_syms, dir_rows[i].typed_st);
		end

		// random part: whole messages, each phase under one mode
		for (int p = 0; p < N_PHASES; p++) begin
			wait_idle();
			write_mode(phase_modes[p]);
			no_gaps = ($urandom_range(0, 3) == 0);
			sent = 0;
			abandon = 1'b0;
			while (sent < PHASE_ITEMS && !abandon) begin
				msg_q.delete();
				if (phase_modes[p] == MODE_ENC) begin
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
						: $urandom_range(1, 9);
					repeat (len) msg_q.push_back(8'($urandom_range(0, 255)));
				end else begin
					// well-formed text of a few groups
					ng = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 6)
						: $urandom_range(1, 3);
					repeat (4 * ng) msg_q.push_back(b64_char(6'($urandom_range(0, 63))));
					pads = $urandom_range(0, 2);
					if (pads >= 1) msg_q[msg_q.size() - 1] = PAD_CHAR;
					if (pads == 2) msg_q[msg_q.size() - 2] = PAD_CHAR;
					// noise: any byte, or a pad in the wrong place
					foreach (msg_q[j]) begin
						if ($urandom_range(0, 19) == 0) begin
							msg_q[j] = 8'($urandom_range(0, 255));
						end else if ($urandom_range(0, 29) == 0) begin
							msg_q[j] = PAD_CHAR;
						end
					end
					// broken length now and then
					if ($urandom_range(0, 9) == 0) begin
						if ($urandom_range(0, 1) == 0) begin
							repeat ($urandom_range(1, 3)) void'(msg_q.pop_back());
						end else begin
							repeat ($urandom_range(1, 3))
								msg_q.push_back(b64_char(6'($urandom_range(0, 63))));
						end
					end
				end
				// sometimes end the phase inside a message, the mode write drops it
				if (sent + msg_q.size() >= PHASE_ITEMS && msg_q.size() > 1
					&& $urandom_range(0, 2) == 0) begin
					abandon = 1'b1;
					void'(msg_q.pop_back());
				end
				foreach (msg_q[j]) begin
					send_symbol(msg_q[j], !abandon && (j == msg_q.size() - 1), -1,
						32'd0, ST_OK);
				end
				sent += msg_q.size();
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d items in, %0d results out, %0d mode writes, long hold %0s",
			n_in, n_out, n_cfg, hold_done ? "seen" : "missed");
		$display("message ends: %0d ok, %0d bad character, %0d bad length",
			n_end_ok, n_end_badchar, n_end_badlen);
		if (err_count == 0 && pending_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

>>> base64_stream_codec.f
rtl/b64_pkg.sv
rtl/base64_stream_codec.sv
test/tb_top.sv
